// ===== rtl/core/quoted_argument_tokenizer_unit_macros.svh =====
// Assertion macros shared by the tokenizer RTL files.
// No dependencies; included by files that carry concurrent checks.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define QATU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define QATU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed (next cycle)");

`else

`define QATU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QATU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/qatu_pkg.sv =====
// Shared types, constants and the per-byte decode functions of the tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package qatu_pkg;

    // Sizes of one result bundle and of the bundle queue.
    localparam int MaxResults = 6;
    localparam int ResCntW    = $clog2(MaxResults + 1);
    localparam int ResIdxW    = $clog2(MaxResults);
    localparam int QueueDepth = 4;

    // Characters with a special meaning.
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChLowX   = 8'h78;
    localparam logic [7:0] ChUpX    = 8'h58;
    localparam logic [9:0] DecLimit = 10'd256;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TEND = 2'd1,
        KIND_DONE = 2'd2,
        KIND_QERR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'd0,
        ESC_SLASH = 3'd1,
        ESC_HEX0  = 3'd2,
        ESC_HEX1  = 3'd3,
        ESC_DEC1  = 3'd4,
        ESC_DEC2  = 3'd5
    } t_esc;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    // All results caused by one accepted byte, oldest in slot 0.
    typedef struct packed {
        t_res [MaxResults-1:0] items;
        logic [ResCntW-1:0]    count;
    } t_bundle;

    typedef struct packed {
        t_quote     qmode;
        t_esc       esc;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       tok_open;
    } t_tok_state;

    typedef struct packed {
        t_tok_state st;
        t_bundle    bun;
    } t_step;

    localparam t_tok_state TokReset = '{
        qmode: QM_NONE, esc: ESC_NONE, lo: 8'h00, hi: 8'h00, tok_open: 1'b0
    };

    function automatic t_bundle add_res(t_bundle b, t_kind k, logic [7:0] d);
        t_bundle r;
        r = b;
        if (b.count < ResCntW'(MaxResults)) begin
            r.items[b.count[ResIdxW-1:0]] = '{kind: k, data: d};
            r.count = b.count + ResCntW'(1);
        end
        return r;
    endfunction

    function automatic t_step send_byte(t_step s, logic [7:0] d);
        t_step r;
        r = s;
        r.bun = add_res(s.bun, KIND_BYTE, d);
        r.st.tok_open = 1'b1;
        return r;
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters a..f and A..F share the low nibble 1..6.
    function automatic logic [3:0] hex_val(logic [7:0] c);
        return is_dec(c) ? c[3:0] : (c[3:0] + 4'd9);
    endfunction

    // Single-character escapes: bit 8 flags a hit, bits 7:0 give the byte.
    function automatic logic [8:0] esc_letter(logic [7:0] c);
        logic [8:0] r;
        unique case (c) inside
            8'h61:   r = {1'b1, 8'h07};  // a
            8'h62:   r = {1'b1, 8'h08};  // b
            8'h65:   r = {1'b1, 8'h1B};  // e
            8'h66:   r = {1'b1, 8'h0C};  // f
            8'h6E:   r = {1'b1, 8'h0A};  // n
            8'h72:   r = {1'b1, 8'h0D};  // r
            8'h74:   r = {1'b1, 8'h09};  // t
            8'h76:   r = {1'b1, 8'h0B};  // v
            ChDquote, ChSquote, ChBslash, ChSpace: r = {1'b1, c};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

    // Handling of a character that is not part of an escape.
    function automatic t_step plain_char(t_step s, logic [7:0] c);
        t_step r;
        r = s;
        if (s.st.qmode == QM_SINGLE) begin
            if (c == ChSquote) r.st.qmode = QM_NONE;
            else r = send_byte(r, c);
        end else if (c == ChBslash) begin
            r.st.esc = ESC_SLASH;
            r.st.lo  = 8'h00;
            r.st.hi  = 8'h00;
        end else if (s.st.qmode == QM_DOUBLE) begin
            if (c == ChDquote) r.st.qmode = QM_NONE;
            else r = send_byte(r, c);
        end else if (c == ChSquote) begin
            r.st.qmode = QM_SINGLE;
        end else if (c == ChDquote) begin
            r.st.qmode = QM_DOUBLE;
        end else if (c == ChSpace) begin
            if (s.st.tok_open) begin
                r.bun = add_res(r.bun, KIND_TEND, 8'h00);
                r.st.tok_open = 1'b0;
            end
        end else begin
            r = send_byte(r, c);
        end
        return r;
    endfunction

    // A broken escape gives back the backslash and its held characters.
    function automatic t_step spill(t_step s, logic [7:0] lo, logic [7:0] hi, logic two);
        t_step r;
        r = send_byte(s, ChBslash);
        r = send_byte(r, lo);
        if (two) r = send_byte(r, hi);
        return r;
    endfunction

    // Full decode of one input byte: next state and the results it causes.
    function automatic t_step tok_step(t_tok_state st, logic [7:0] c, logic last);
        t_step      s;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [8:0] let_hit;
        logic [9:0] dval;
        logic       cond;
        s.st   = st;
        s.bun  = '0;
        lo     = st.lo;
        hi     = st.hi;
        let_hit = esc_letter(c);
        // 100 = 64 + 32 + 4 and 10 = 8 + 2, so the digit sum needs no multiplier.
        dval = (10'(lo[3:0]) << 6) + (10'(lo[3:0]) << 5) + (10'(lo[3:0]) << 2) +
               (10'(hi[3:0]) << 3) + (10'(hi[3:0]) << 1) + 10'(c[3:0]);
        cond = (st.esc == ESC_HEX0) ? is_hex(c) : is_dec(c);

        unique case (st.esc) inside
            ESC_SLASH: begin
                s.st.esc = ESC_NONE;
                if (let_hit[8]) begin
                    s = send_byte(s, let_hit[7:0]);
                end else if ((c == ChLowX) || (c == ChUpX)) begin
                    s.st.esc = ESC_HEX0;
                    s.st.lo  = c;
                    s.st.hi  = 8'h00;
                end else if (is_dec(c)) begin
                    s.st.esc = ESC_DEC1;
                    s.st.lo  = c;
                    s.st.hi  = 8'h00;
                end else begin
                    s = send_byte(s, ChBslash);
                    s = send_byte(s, c);
                end
            end
            ESC_HEX0, ESC_DEC1: begin
                if (cond) begin
                    s.st.esc = (st.esc == ESC_HEX0) ? ESC_HEX1 : ESC_DEC2;
                    s.st.hi  = c;
                end else begin
                    s.st.esc = ESC_NONE;
                    s.st.lo  = 8'h00;
                    s.st.hi  = 8'h00;
                    s = spill(s, lo, hi, 1'b0);
                    s = plain_char(s, c);
                end
            end
            ESC_HEX1: begin
                s.st.esc = ESC_NONE;
                s.st.lo  = 8'h00;
                s.st.hi  = 8'h00;
                if (is_hex(c)) begin
                    s = send_byte(s, {hex_val(hi), hex_val(c)});
                end else begin
                    s = spill(s, lo, hi, 1'b1);
                    s = plain_char(s, c);
                end
            end
            ESC_DEC2: begin
                s.st.esc = ESC_NONE;
                s.st.lo  = 8'h00;
                s.st.hi  = 8'h00;
                if (is_dec(c) && (dval < DecLimit)) begin
                    s = send_byte(s, dval[7:0]);
                end else begin
                    s = spill(s, lo, hi, 1'b1);
                    s = plain_char(s, c);
                end
            end
            default: begin
                s = plain_char(s, c);
            end
        endcase

        // End of line: verdict; a pending escape is flushed unless a quote is open.
        if (last) begin
            if ((s.st.qmode == QM_SINGLE) || (s.st.qmode == QM_DOUBLE)) begin
                s.bun = add_res(s.bun, KIND_QERR, 8'h00);
            end else begin
                unique case (s.st.esc) inside
                    ESC_SLASH:          s = send_byte(s, ChBslash);
                    ESC_HEX0, ESC_DEC1: s = spill(s, s.st.lo, s.st.hi, 1'b0);
                    ESC_HEX1, ESC_DEC2: s = spill(s, s.st.lo, s.st.hi, 1'b1);
                    default:            s = s;
                endcase
                if (s.st.tok_open) s.bun = add_res(s.bun, KIND_TEND, 8'h00);
                s.bun = add_res(s.bun, KIND_DONE, 8'h00);
            end
            s.st = TokReset;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qatu_front.sv =====
// Front end: accepts input bytes, decodes quoting and escapes, builds result bundles.
// Depends on qatu_pkg and the assertion macro header.
`default_nettype none
`include "quoted_argument_tokenizer_unit_macros.svh"

module qatu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_line_last,
    input  wire logic              i_q_full,
    output logic                   o_q_wr,
    output qatu_pkg::t_bundle      o_q_data
);

    qatu_pkg::t_tok_state r_st;
    qatu_pkg::t_tok_state n_st;
    qatu_pkg::t_step      w_step;
    logic                 w_accept;

    // The front stalls only when the bundle queue has no room.
    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;

    // Decode the incoming byte against the current tokenizer state.
    always_comb begin
        w_step = qatu_pkg::tok_step(r_st, i_in_byte, i_line_last);
    end

    // Next state advances only on an accepted item.
    always_comb begin
        n_st = w_accept ? w_step.st : r_st;
    end

    // A bundle goes to the queue only if the item caused results.
    always_comb begin
        o_q_data = w_step.bun;
        o_q_wr   = w_accept && (w_step.bun.count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= qatu_pkg::TokReset;
        end else begin
            r_st <= n_st;
        end
    end

    `QATU_ASSERT_NEXT(a_line_end_resets, i_clk, i_rst_n, w_accept && i_line_last, r_st == qatu_pkg::TokReset)
    `QATU_ASSERT_IMPL(a_line_end_reports, i_clk, i_rst_n, w_accept && i_line_last, o_q_wr)

endmodule

`default_nettype wire

// ===== rtl/core/qatu_fifo.sv =====
// Short queue of result bundles between the front end and the back end.
// Depends on qatu_pkg and the assertion macro header.
`default_nettype none
`include "quoted_argument_tokenizer_unit_macros.svh"

module qatu_fifo #(
    parameter int DEPTH = qatu_pkg::QueueDepth  // 2 to 32 entries
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire qatu_pkg::t_bundle i_wdata,
    output logic                   o_full,
    input  wire logic              i_rd,
    output qatu_pkg::t_bundle      o_rdata,
    output logic                   o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    qatu_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     n_wp;
    logic [AW-1:0]     r_rp;
    logic [AW-1:0]     n_rp;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // Pointer and fill-count update; pointers wrap at the depth.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : (r_wp + AW'(1));
        if (w_rd) n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : (r_rp + AW'(1));
        if (w_wr && !w_rd) n_cnt = r_cnt + CW'(1);
        else if (w_rd && !w_wr) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    `QATU_ASSERT_IMPL(a_fifo_no_overflow, i_clk, i_rst_n, i_wr, !o_full)

endmodule

`default_nettype wire

// ===== rtl/core/qatu_back.sv =====
// Back end: unpacks result bundles and presents one result item per pop.
// Depends on qatu_pkg and the assertion macro header.
`default_nettype none
`include "quoted_argument_tokenizer_unit_macros.svh"

module qatu_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire qatu_pkg::t_bundle i_q_data,
    output logic                   o_q_rd,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [1:0]             o_out_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_run_last
);

    localparam int IW = qatu_pkg::ResIdxW;
    localparam int CW = qatu_pkg::ResCntW;

    logic              r_valid;
    logic              n_valid;
    qatu_pkg::t_bundle r_bun;
    qatu_pkg::t_bundle n_bun;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic              w_last;
    logic              w_adv;
    logic              w_load;
    qatu_pkg::t_res    w_cur;

    // Current result comes from the held bundle; the last slot closes the item.
    assign w_last  = ((CW'(r_idx) + CW'(1)) == r_bun.count);
    assign w_adv   = r_valid && i_pop;
    assign w_load  = (!r_valid || (w_adv && w_last)) && !i_q_empty;
    assign o_q_rd  = w_load;
    assign o_empty = !r_valid;
    assign w_cur   = r_bun.items[r_idx];

    always_comb begin
        o_out_kind = w_cur.kind;
        o_out_byte = w_cur.data;
        o_run_last = w_last;
    end

    // Load a new bundle, step through slots, or go empty.
    always_comb begin
        n_valid = r_valid;
        n_bun   = r_bun;
        n_idx   = r_idx;
        if (w_load) begin
            n_valid = 1'b1;
            n_bun   = i_q_data;
            n_idx   = '0;
        end else if (w_adv && w_last) begin
            n_valid = 1'b0;
        end else if (w_adv) begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bun <= n_bun;
    end

    `QATU_ASSERT_IMPL(a_back_count_nonzero, i_clk, i_rst_n, r_valid, r_bun.count != '0)
    `QATU_ASSERT_IMPL(a_back_idx_in_range, i_clk, i_rst_n, r_valid, CW'(r_idx) < r_bun.count)
    `QATU_ASSERT_NEXT(a_back_mid_bundle_holds, i_clk, i_rst_n, w_adv && !w_last, r_valid)

endmodule

`default_nettype wire

// ===== rtl/core/quoted_argument_tokenizer_unit.sv =====
// Top level of the quoted argument tokenizer: front end, bundle queue, back end.
// Depends on qatu_pkg, qatu_front, qatu_fifo and qatu_back.
//
//  Channel | Handshake         | Payload                                | Direction
//  --------+-------------------+----------------------------------------+----------
//  input   | push / full       | i_in_byte, i_line_last                 | in
//  result  | empty / pop       | o_out_kind, o_out_byte, o_run_last     | out
//
// One input item is accepted per cycle while the bundle queue has room.
// Results leave one per cycle from the back-end register while pop is asserted and
// results wait; the first result of an item passes through the bundle queue and is
// then loaded into the back-end register, when the back end is free.
// Reset (synchronous, active low) returns to unquoted, no escape, queue empty.
// full rises when QUEUE_DEPTH bundles wait; a stalled result holds until popped.
`default_nettype none

module quoted_argument_tokenizer_unit #(
    parameter int QUEUE_DEPTH = qatu_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_line_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);

    logic              w_q_full;
    logic              w_q_wr;
    qatu_pkg::t_bundle w_q_wdata;
    logic              w_q_empty;
    logic              w_q_rd;
    qatu_pkg::t_bundle w_q_rdata;

    qatu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in_byte   (i_in_byte),
        .i_line_last (i_line_last),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr),
        .o_q_data    (w_q_wdata)
    );

    qatu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    qatu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_rdata),
        .o_q_rd     (w_q_rd),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_kind (o_out_kind),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

`default_nettype wire
